@@ rtl/core/i2cbb_pkg.sv @@
// shared types and constants for the i2c bit-bang master
package i2cbb_pkg;

  // raw function codes on the input item
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_START    = 3'd1;
  localparam logic [2:0] FUNC_STOP     = 3'd2;
  localparam logic [2:0] FUNC_WRITE    = 3'd3;
  localparam logic [2:0] FUNC_WAIT_ACK = 3'd4;
  localparam logic [2:0] FUNC_READ     = 3'd5;

  // classified commands handed from front to engine
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd4;
  localparam logic [2:0] CMD_READ     = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_COND_TICKS     = 3'd0;
  localparam logic [2:0] REG_BIT_TICKS      = 3'd1;
  localparam logic [2:0] REG_READ_BIT_TICKS = 3'd2;
  localparam logic [2:0] REG_ACK_POLL_LIMIT = 3'd3;
  localparam logic [2:0] REG_ACK_HOLD_TICKS = 3'd4;

  // configuration reset values
  localparam logic [7:0] COND_TICKS_RST     = 8'd14;
  localparam logic [7:0] BIT_TICKS_RST      = 8'd15;
  localparam logic [7:0] READ_BIT_TICKS_RST = 8'd50;
  localparam logic [7:0] ACK_POLL_LIMIT_RST = 8'd250;
  localparam logic [7:0] ACK_HOLD_TICKS_RST = 8'd10;

  // queue depths on both sides of the engine
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned RQ_DEPTH = 2;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
  } out_item_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } cmd_q_t;

endpackage

@@ rtl/core/i2cbb_front.sv @@
// front end: accepts items, classifies the function code and queues commands
module i2cbb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  i2cbb_pkg::in_item_t in_data,
  output i2cbb_pkg::cmd_q_t   cq_head,
  input  logic                cq_pop
);
  import i2cbb_pkg::*;

  localparam int unsigned PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CQ_DEPTH + 1);

  cmd_item_t       slot_r [CQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;
  cmd_item_t       classified;

  // map function codes to commands, unused codes act as a tick
  always_comb begin
    classified.data_byte = in_data.data_byte;
    classified.send_ack  = in_data.send_ack;
    classified.sda_in    = in_data.sda_in;
    unique case (in_data.func)
      FUNC_START:    classified.cmd = CMD_START;
      FUNC_STOP:     classified.cmd = CMD_STOP;
      FUNC_WRITE:    classified.cmd = CMD_WRITE;
      FUNC_WAIT_ACK: classified.cmd = CMD_WAIT_ACK;
      FUNC_READ:     classified.cmd = CMD_READ;
      default:       classified.cmd = CMD_TICK;
    endcase
  end

  assign full    = (cnt_r == CW'(CQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = cq_pop && (cnt_r != '0);

  assign cq_head.valid = (cnt_r != '0);
  assign cq_head.item  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= classified;
    end
  end

endmodule

@@ rtl/core/i2cbb_engine.sv @@
// back end: bit-timing sequencer, configuration registers and result queue
module i2cbb_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cbb_pkg::cmd_q_t    cq_head,
  output logic                 cq_pop,
  input  logic                 cfg_wr,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 out_pop,
  output logic                 out_empty,
  output i2cbb_pkg::out_item_t out_data
);
  import i2cbb_pkg::*;

  // sequencer phase codes
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_SP_A    = 4'd3;
  localparam logic [3:0] PH_SP_B    = 4'd4;
  localparam logic [3:0] PH_WR_LO   = 4'd5;
  localparam logic [3:0] PH_WR_HI   = 4'd6;
  localparam logic [3:0] PH_WA_LO   = 4'd7;
  localparam logic [3:0] PH_WA_HI   = 4'd8;
  localparam logic [3:0] PH_WA_POLL = 4'd9;
  localparam logic [3:0] PH_WA_HOLD = 4'd10;
  localparam logic [3:0] PH_RD_LO   = 4'd11;
  localparam logic [3:0] PH_RD_HI   = 4'd12;
  localparam logic [3:0] PH_AK_LO   = 4'd13;
  localparam logic [3:0] PH_AK_HI   = 4'd14;

  localparam int unsigned PW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RQ_DEPTH + 1);

  // configuration registers
  logic [7:0] cond_ticks_r, bit_ticks_r, read_bit_ticks_r;
  logic [7:0] ack_poll_limit_r, ack_hold_ticks_r;

  // sequencer state
  logic [3:0] phase_r, phase_nxt;
  logic [3:0] bit_idx_r, bit_idx_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic       err_r, err_nxt;
  logic [7:0] rx_r, rx_nxt;

  logic       done;
  logic       step;
  logic       timed;
  logic [7:0] limit;
  logic [7:0] tc_inc;
  logic       expired;
  logic [3:0] bit_inc;
  cmd_item_t  cur;
  out_item_t  result;

  // result queue
  out_item_t     rq_r [RQ_DEPTH];
  logic [PW-1:0] rq_wr_r, rq_rd_r;
  logic [CW-1:0] rq_cnt_r;
  logic          rq_pop;

  assign cur     = cq_head.item;
  assign step    = cq_head.valid && (rq_cnt_r != CW'(RQ_DEPTH));
  assign cq_pop  = step;
  assign rq_pop  = out_pop && (rq_cnt_r != '0);

  // phase length for the current phase
  always_comb begin
    timed = 1'b1;
    unique case (phase_r)
      PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WA_LO, PH_WA_HI: limit = cond_ticks_r;
      PH_WR_LO, PH_WR_HI, PH_AK_LO, PH_AK_HI:                 limit = bit_ticks_r;
      PH_RD_LO, PH_RD_HI:                                     limit = read_bit_ticks_r;
      PH_WA_HOLD:                                             limit = ack_hold_ticks_r;
      default: begin
        limit = cond_ticks_r;
        timed = 1'b0;
      end
    endcase
  end

  assign tc_inc  = tick_r + 8'd1;
  assign expired = (tc_inc >= limit);
  assign bit_inc = bit_idx_r + 4'd1;

  // next state for one item
  always_comb begin
    phase_nxt      = phase_r;
    bit_idx_nxt    = bit_idx_r;
    tick_nxt       = tick_r;
    poll_nxt       = poll_r;
    shift_nxt      = shift_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_choice_nxt = ack_choice_r;
    err_nxt        = err_r;
    rx_nxt         = rx_r;
    done           = 1'b0;
    if (phase_r == PH_IDLE) begin
      // command start, only while idle
      if (cur.cmd != CMD_TICK) begin
        err_nxt     = 1'b0;
        bit_idx_nxt = '0;
        poll_nxt    = '0;
        tick_nxt    = '0;
        unique case (cur.cmd)
          CMD_START: begin
            sda_nxt   = 1'b1;
            scl_nxt   = 1'b1;
            phase_nxt = PH_ST_A;
          end
          CMD_STOP: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            phase_nxt = PH_SP_A;
          end
          CMD_WRITE: begin
            scl_nxt   = 1'b0;
            sda_nxt   = cur.data_byte[7];
            shift_nxt = {cur.data_byte[6:0], 1'b0};
            phase_nxt = PH_WR_LO;
          end
          CMD_WAIT_ACK: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            phase_nxt = PH_WA_LO;
          end
          CMD_READ: begin
            ack_choice_nxt = cur.send_ack;
            shift_nxt      = '0;
            scl_nxt        = 1'b0;
            sda_nxt        = 1'b1;
            phase_nxt      = PH_RD_LO;
          end
          default: begin
            tick_nxt = tick_r;
          end
        endcase
      end
    end else begin
      // one tick of a running sequence
      if (timed) begin
        tick_nxt = expired ? 8'd0 : tc_inc;
      end
      unique case (phase_r)
        PH_ST_A: if (expired) begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_ST_B;
        end
        PH_ST_B: if (expired) begin
          scl_nxt = 1'b0;
          done    = 1'b1;
        end
        PH_SP_A: if (expired) begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_SP_B;
        end
        PH_SP_B: if (expired) begin
          sda_nxt = 1'b1;
          done    = 1'b1;
        end
        PH_WR_LO: if (expired) begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_WR_HI;
        end
        PH_WR_HI: if (expired) begin
          bit_idx_nxt = bit_inc;
          scl_nxt     = 1'b0;
          if (bit_inc >= 4'd8) begin
            done = 1'b1;
          end else begin
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_WR_LO;
          end
        end
        PH_WA_LO: if (expired) begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_WA_HI;
        end
        PH_WA_HI: if (expired) begin
          phase_nxt = PH_WA_POLL;
        end
        PH_WA_POLL: begin
          if (!cur.sda_in) begin
            scl_nxt = 1'b0;
            if (ack_hold_ticks_r == 8'd0) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_WA_HOLD;
              tick_nxt  = '0;
            end
          end else if (poll_r == ack_poll_limit_r) begin
            // ack timeout, fall into a stop sequence
            err_nxt   = 1'b1;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            phase_nxt = PH_SP_A;
            tick_nxt  = '0;
          end else begin
            poll_nxt = poll_r + 8'd1;
          end
        end
        PH_WA_HOLD: if (expired) begin
          done = 1'b1;
        end
        PH_RD_LO: if (expired) begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RD_HI;
        end
        PH_RD_HI: if (expired) begin
          shift_nxt   = {shift_r[6:0], cur.sda_in};
          bit_idx_nxt = bit_inc;
          scl_nxt     = 1'b0;
          if (bit_inc >= 4'd8) begin
            sda_nxt   = !ack_choice_r;
            phase_nxt = PH_AK_LO;
          end else begin
            phase_nxt = PH_RD_LO;
          end
        end
        PH_AK_LO: if (expired) begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_AK_HI;
        end
        PH_AK_HI: if (expired) begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
          rx_nxt  = shift_r;
          done    = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      if (done) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // result item for this step
  always_comb begin
    result.scl_level   = scl_nxt;
    result.sda_release = sda_nxt;
    result.busy_res    = (phase_nxt != PH_IDLE);
    result.done_res    = done;
    result.ack_error   = done && err_nxt;
    result.read_data   = rx_nxt;
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_idx_r    <= '0;
      tick_r       <= '0;
      poll_r       <= '0;
      shift_r      <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      ack_choice_r <= 1'b0;
      err_r        <= 1'b0;
      rx_r         <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      bit_idx_r    <= bit_idx_nxt;
      tick_r       <= tick_nxt;
      poll_r       <= poll_nxt;
      shift_r      <= shift_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_choice_r <= ack_choice_nxt;
      err_r        <= err_nxt;
      rx_r         <= rx_nxt;
    end
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cond_ticks_r     <= COND_TICKS_RST;
      bit_ticks_r      <= BIT_TICKS_RST;
      read_bit_ticks_r <= READ_BIT_TICKS_RST;
      ack_poll_limit_r <= ACK_POLL_LIMIT_RST;
      ack_hold_ticks_r <= ACK_HOLD_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_COND_TICKS:     cond_ticks_r     <= cfg_data;
        REG_BIT_TICKS:      bit_ticks_r      <= cfg_data;
        REG_READ_BIT_TICKS: read_bit_ticks_r <= cfg_data;
        REG_ACK_POLL_LIMIT: ack_poll_limit_r <= cfg_data;
        REG_ACK_HOLD_TICKS: ack_hold_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (step) begin
        rq_wr_r <= (rq_wr_r == PW'(RQ_DEPTH - 1)) ? '0 : rq_wr_r + PW'(1);
      end
      if (rq_pop) begin
        rq_rd_r <= (rq_rd_r == PW'(RQ_DEPTH - 1)) ? '0 : rq_rd_r + PW'(1);
      end
      rq_cnt_r <= rq_cnt_r + CW'(step) - CW'(rq_pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (step) begin
      rq_r[rq_wr_r] <= result;
    end
  end

  assign out_empty = (rq_cnt_r == '0);
  assign out_data  = rq_r[rq_rd_r];

endmodule

@@ rtl/core/i2c_bitbang_master.sv @@
// top level of the byte-level i2c bit-bang master
// Byte-level I2C master that times SCL and SDA in ticks: every input item is
// either a tick or a command (start, stop, write byte, wait for ack, read byte),
// and every item yields exactly one result item with the pin levels, busy,
// done, ack error and the last received byte. Commands given while a sequence
// runs count as plain ticks. One item is taken per clock cycle while the
// command queue has room and the result queue can take results; the command
// queue registers the item when it is accepted and the sequencer writes its
// result into the result queue, from where it can be popped on the out_
// ports. The sequencer step, combinational logic around an 8-bit tick add
// and compare per item, sets the rate.
// Both sides have a two-entry queue, so either side may stall without
// stopping the other until a queue fills. Configuration writes are taken at
// any cycle (cfg_ready is always high) and are meant for an idle block.
module i2c_bitbang_master (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  i2cbb_pkg::in_item_t  in_data,
  input  logic                 out_pop,
  output logic                 out_empty,
  output i2cbb_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import i2cbb_pkg::*;

  cmd_q_t cq_head;
  logic   cq_pop;

  assign cfg_ready = 1'b1;

  // front end with command queue
  i2cbb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .in_data (in_data),
    .cq_head (cq_head),
    .cq_pop  (cq_pop)
  );

  // sequencer with result queue
  i2cbb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_head   (cq_head),
    .cq_pop    (cq_pop),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/i2cbb_checker.sv @@
// port-level checks for the i2c bit-bang master and their bind
module i2cbb_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_pop,
  input logic                 out_empty,
  input i2cbb_pkg::out_item_t out_data
);

  // reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a finishing item never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.done_res) |-> !out_data.busy_res)
    else $error("done and busy together");

  // ack error only comes with done
  a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.ack_error) |-> out_data.done_res)
    else $error("ack error without done");

  // a waiting item stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting item changed");

endmodule

bind i2c_bitbang_master i2cbb_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_data  (out_data)
);

@@ verif/tb_top.sv @@
// testbench for the i2c bit-bang master: predicts every result item and checks the queue output
`timescale 1ns / 100ps

module tb_top;
  import i2cbb_pkg::*;

  // function codes the block treats as plain ticks
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  // sequencer phases of the bus model
  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_START_A, SEQ_START_B, SEQ_STOP_A, SEQ_STOP_B,
    SEQ_WR_LO, SEQ_WR_HI, SEQ_ACKW_LO, SEQ_ACKW_HI, SEQ_ACKW_POLL, SEQ_ACKW_HOLD,
    SEQ_RD_LO, SEQ_RD_HI, SEQ_ACKO_LO, SEQ_ACKO_HI
  } seq_phase_t;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  in_item_t   in_data;
  logic       out_pop;
  logic       out_empty;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  // bus model: timing registers and sequencer state
  logic [7:0] cfg_cond, cfg_bit, cfg_rdbit, cfg_poll_lim, cfg_hold;
  seq_phase_t seq_phase;
  logic [3:0] bit_cnt;
  logic [7:0] tick_cnt, poll_cnt, shifter, rx_q;
  logic       scl_q, sda_q, ack_sel, err_flag;

  out_item_t bus_items_due[$];
  out_item_t want_item;
  int        fail_count;
  int        stall_left;
  bit        quiet_tail;

  i2c_bitbang_master u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one tick of a phase lasting n ticks; a zero count acts as one
  function automatic logic count_tick(input logic [7:0] n);
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt >= n) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void goto_phase(input seq_phase_t p);
    seq_phase = p;
    tick_cnt  = '0;
  endfunction

  // drive the next data bit, msb first
  function automatic void load_write_bit();
    scl_q   = 1'b0;
    sda_q   = shifter[7];
    shifter = shifter << 1;
    goto_phase(SEQ_WR_LO);
  endfunction

  // one tick of a running sequence, returns 1 when the command completes
  function automatic logic advance_seq(input logic sda);
    logic fin;
    fin = 1'b0;
    case (seq_phase)
      SEQ_START_A: if (count_tick(cfg_cond)) begin
        sda_q = 1'b0;
        goto_phase(SEQ_START_B);
      end
      SEQ_START_B: if (count_tick(cfg_cond)) begin
        scl_q = 1'b0;
        fin   = 1'b1;
      end
      SEQ_STOP_A: if (count_tick(cfg_cond)) begin
        scl_q = 1'b1;
        goto_phase(SEQ_STOP_B);
      end
      SEQ_STOP_B: if (count_tick(cfg_cond)) begin
        sda_q = 1'b1;
        fin   = 1'b1;
      end
      SEQ_WR_LO: if (count_tick(cfg_bit)) begin
        scl_q = 1'b1;
        goto_phase(SEQ_WR_HI);
      end
      SEQ_WR_HI: if (count_tick(cfg_bit)) begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= 4'd8) begin
          scl_q = 1'b0;
          fin   = 1'b1;
        end else begin
          load_write_bit();
        end
      end
      SEQ_ACKW_LO: if (count_tick(cfg_cond)) begin
        scl_q = 1'b1;
        goto_phase(SEQ_ACKW_HI);
      end
      SEQ_ACKW_HI: if (count_tick(cfg_cond)) goto_phase(SEQ_ACKW_POLL);
      // low sample is an ack, too many high samples fall into a stop with error
      SEQ_ACKW_POLL: begin
        if (!sda) begin
          scl_q = 1'b0;
          if (cfg_hold == 8'd0) fin = 1'b1;
          else goto_phase(SEQ_ACKW_HOLD);
        end else if (poll_cnt == cfg_poll_lim) begin
          err_flag = 1'b1;
          scl_q    = 1'b0;
          sda_q    = 1'b0;
          goto_phase(SEQ_STOP_A);
        end else begin
          poll_cnt = poll_cnt + 8'd1;
        end
      end
      SEQ_ACKW_HOLD: if (count_tick(cfg_hold)) fin = 1'b1;
      SEQ_RD_LO: if (count_tick(cfg_rdbit)) begin
        scl_q = 1'b1;
        goto_phase(SEQ_RD_HI);
      end
      SEQ_RD_HI: if (count_tick(cfg_rdbit)) begin
        shifter = {shifter[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        scl_q   = 1'b0;
        if (bit_cnt >= 4'd8) begin
          sda_q = !ack_sel;
          goto_phase(SEQ_ACKO_LO);
        end else begin
          goto_phase(SEQ_RD_LO);
        end
      end
      SEQ_ACKO_LO: if (count_tick(cfg_bit)) begin
        scl_q = 1'b1;
        goto_phase(SEQ_ACKO_HI);
      end
      SEQ_ACKO_HI: if (count_tick(cfg_bit)) begin
        scl_q = 1'b0;
        sda_q = 1'b1;
        rx_q  = shifter;
        fin   = 1'b1;
      end
      default: seq_phase = SEQ_IDLE;
    endcase
    return fin;
  endfunction

  // expected result for one accepted item
  function automatic out_item_t predict_bus_item(input in_item_t it);
    out_item_t res;
    logic      fin;
    fin = 1'b0;
    if (seq_phase == SEQ_IDLE) begin
      if (it.func != FUNC_TICK && it.func <= FUNC_READ) begin
        err_flag = 1'b0;
        bit_cnt  = '0;
        poll_cnt = '0;
        case (it.func)
          FUNC_START: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
            goto_phase(SEQ_START_A);
          end
          FUNC_STOP: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
            goto_phase(SEQ_STOP_A);
          end
          FUNC_WRITE: begin
            shifter = it.data_byte;
            load_write_bit();
          end
          FUNC_WAIT_ACK: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            goto_phase(SEQ_ACKW_LO);
          end
          default: begin
            ack_sel = it.send_ack;
            shifter = '0;
            scl_q   = 1'b0;
            sda_q   = 1'b1;
            goto_phase(SEQ_RD_LO);
          end
        endcase
      end
    end else begin
      fin = advance_seq(it.sda_in);
    end
    if (fin) seq_phase = SEQ_IDLE;
    res.scl_level   = scl_q;
    res.sda_release = sda_q;
    res.busy_res    = (seq_phase != SEQ_IDLE);
    res.done_res    = fin;
    res.ack_error   = fin & err_flag;
    res.read_data   = rx_q;
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] func, input logic [7:0] data,
                                         input logic ack, input logic sda);
    in_item_t it;
    it.func      = func;
    it.data_byte = data;
    it.send_ack  = ack;
    it.sda_in    = sda;
    return it;
  endfunction

  // push one item, with an occasional gap in front of it
  task automatic send_item(input in_item_t it);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    bus_items_due.push_back(predict_bus_item(it));
  endtask

  // hold off the sender until every expected item has come back
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (bus_items_due.size() != 0);
  endtask

  task automatic cfg_write_one(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COND_TICKS:     cfg_cond     = val;
      REG_BIT_TICKS:      cfg_bit      = val;
      REG_READ_BIT_TICKS: cfg_rdbit    = val;
      REG_ACK_POLL_LIMIT: cfg_poll_lim = val;
      REG_ACK_HOLD_TICKS: cfg_hold     = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] cond, input logic [7:0] bitv,
                            input logic [7:0] rd, input logic [7:0] poll,
                            input logic [7:0] hold);
    drain_results();
    cfg_write_one(REG_COND_TICKS, cond);
    cfg_write_one(REG_BIT_TICKS, bitv);
    cfg_write_one(REG_READ_BIT_TICKS, rd);
    cfg_write_one(REG_ACK_POLL_LIMIT, poll);
    cfg_write_one(REG_ACK_HOLD_TICKS, hold);
  endtask

  // issue one command from idle and tick it to completion;
  // ack_after is the number of high ack polls before sda goes low
  task automatic run_cmd(input logic [2:0] func, input logic [7:0] data, input logic ack,
                         input int ack_after, input bit noisy);
    int         highs;
    logic [2:0] f;
    logic       sda;
    highs = 0;
    send_item(make_item(func, data, ack, 1'($urandom_range(0, 1))));
    while (seq_phase != SEQ_IDLE) begin
      f   = noisy ? 3'($urandom_range(0, 7)) : FUNC_TICK;
      sda = 1'($urandom_range(0, 1));
      if (seq_phase == SEQ_ACKW_POLL) begin
        sda = (highs >= ack_after) ? 1'b0 : 1'b1;
        highs++;
      end
      send_item(make_item(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda));
    end
  endtask

  // random commands run to completion, with idle noise and commands while busy
  task automatic run_traffic(input int n_items);
    int         counted;
    int         pick;
    logic [2:0] f;
    logic       sda;
    counted = 0;
    while (counted < n_items || seq_phase != SEQ_IDLE) begin
      pick = $urandom_range(0, 9);
      sda  = 1'($urandom_range(0, 1));
      if (seq_phase == SEQ_ACKW_POLL) sda = ($urandom_range(0, 3) != 0);
      if (seq_phase == SEQ_IDLE) begin
        if (pick < 8) begin
          f = 3'($urandom_range(FUNC_START, FUNC_READ));
          counted++;
        end else if (pick == 8) begin
          f = FUNC_TICK;
        end else begin
          f = ($urandom_range(0, 1) != 0) ? FUNC_RSVD6 : FUNC_RSVD7;
        end
      end else begin
        counted++;
        f = (pick < 7) ? FUNC_TICK : 3'($urandom_range(0, 7));
      end
      send_item(make_item(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sda));
    end
  endtask

  // idle ticks and reserved codes, then reset timing on the short commands
  task automatic test_idle_and_defaults();
    send_item(make_item(FUNC_TICK, 8'h00, 1'b0, 1'b0));
    send_item(make_item(FUNC_RSVD6, 8'hff, 1'b1, 1'b1));
    send_item(make_item(FUNC_RSVD7, 8'h5a, 1'b0, 1'b1));
    run_cmd(FUNC_START, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 3, 1'b0);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  task automatic test_fast_timing();
    write_regs(8'd1, 8'd1, 8'd1, 8'd3, 8'd0);
    run_cmd(FUNC_START, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(FUNC_WRITE, 8'h00, 1'b0, 0, 1'b1);
    run_cmd(FUNC_WRITE, 8'hff, 1'b0, 0, 1'b0);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 3, 1'b0);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 1000, 1'b0);
    run_cmd(FUNC_READ, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(FUNC_READ, 8'h00, 1'b1, 0, 1'b1);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  // zero counts act as one tick, a zero poll limit times out on the first high
  task automatic test_zero_ticks();
    write_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_cmd(FUNC_START, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(FUNC_WRITE, 8'h5a, 1'b0, 0, 1'b0);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 1000, 1'b0);
    run_cmd(FUNC_READ, 8'h00, 1'b1, 0, 1'b0);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  // the longest count, on the hold after a good ack
  task automatic test_max_ticks();
    write_regs(8'd1, 8'd1, 8'd1, 8'd255, 8'd255);
    run_cmd(FUNC_WAIT_ACK, 8'h00, 1'b0, 2, 1'b0);
  endtask

  // writes past the last register must leave the timing alone
  task automatic test_bad_index();
    write_regs(8'd2, 8'd2, 8'd2, 8'd2, 8'd2);
    for (int i = 32'(REG_ACK_HOLD_TICKS) + 1; i < 8; i++)
      cfg_write_one(3'(i), 8'($urandom_range(0, 255)));
    run_cmd(FUNC_START, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, 0, 1'b0);
  endtask

  task automatic test_random_traffic();
    repeat (2) begin
      write_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                 8'($urandom_range(1, 3)), 8'($urandom_range(1, 6)),
                 8'($urandom_range(0, 3)));
      run_traffic(100);
    end
  endtask

  task automatic test_back_to_back();
    write_regs(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
               8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)),
               8'($urandom_range(0, 2)));
    quiet_tail = 1'b1;
    run_traffic(60);
  endtask

  // result side: random pop stalls and comparison with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop    <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (bus_items_due.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want_item = bus_items_due.pop_front();
          if (out_data.scl_level !== want_item.scl_level) begin
            $error("scl_level: expected %0d, actual %0d", want_item.scl_level,
                   out_data.scl_level);
            fail_count++;
          end
          if (out_data.sda_release !== want_item.sda_release) begin
            $error("sda_release: expected %0d, actual %0d", want_item.sda_release,
                   out_data.sda_release);
            fail_count++;
          end
          if (out_data.busy_res !== want_item.busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want_item.busy_res,
                   out_data.busy_res);
            fail_count++;
          end
          if (out_data.done_res !== want_item.done_res) begin
            $error("done_res: expected %0d, actual %0d", want_item.done_res,
                   out_data.done_res);
            fail_count++;
          end
          if (out_data.ack_error !== want_item.ack_error) begin
            $error("ack_error: expected %0d, actual %0d", want_item.ack_error,
                   out_data.ack_error);
            fail_count++;
          end
          if (out_data.read_data !== want_item.read_data) begin
            $error("read_data: expected 0x%02h, actual 0x%02h", want_item.read_data,
                   out_data.read_data);
            fail_count++;
          end
        end
      end
      if (!quiet_tail && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 3);
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    fail_count = 0;
    quiet_tail = 1'b0;
    // model state after reset
    cfg_cond     = COND_TICKS_RST;
    cfg_bit      = BIT_TICKS_RST;
    cfg_rdbit    = READ_BIT_TICKS_RST;
    cfg_poll_lim = ACK_POLL_LIMIT_RST;
    cfg_hold     = ACK_HOLD_TICKS_RST;
    seq_phase    = SEQ_IDLE;
    bit_cnt      = '0;
    tick_cnt     = '0;
    poll_cnt     = '0;
    shifter      = '0;
    rx_q         = '0;
    scl_q        = 1'b1;
    sda_q        = 1'b1;
    ack_sel      = 1'b0;
    err_flag     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_and_defaults();
    test_fast_timing();
    test_zero_ticks();
    test_max_ticks();
    test_bad_index();
    test_random_traffic();
    test_back_to_back();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ i2c_bitbang_master.f @@
rtl/core/i2cbb_pkg.sv
rtl/core/i2cbb_front.sv
rtl/core/i2cbb_engine.sv
rtl/core/i2c_bitbang_master.sv
rtl/core/i2cbb_checker.sv
verif/tb_top.sv
